[sv/bap_pkg.sv]
// Shared types and constants for the block-average pixelate block.
// No dependencies; imported by the top level.
`default_nettype none
package bap_pkg;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MODS = 6'b000010,
      ST_READ = 6'b000100,
      ST_MULT = 6'b001000,
      ST_DIVD = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   localparam logic [2:0] REG_BLOCK_SIZE    = 3'd0;
   localparam logic [2:0] REG_REGION_LEFT   = 3'd1;
   localparam logic [2:0] REG_REGION_TOP    = 3'd2;
   localparam logic [2:0] REG_REGION_RIGHT  = 3'd3;
   localparam logic [2:0] REG_REGION_BOTTOM = 3'd4;
   localparam logic [2:0] REG_COLOR_MODE    = 3'd5;

   localparam int PIX_W = 8;
   localparam int CFG_W = 12;

endpackage
`default_nettype wire

[sv/bap_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module bap_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

[sv/block_average_pixelate.sv]
// Top level of the block-average pixelate block: tile tracking, accumulator
// read-modify-write and the mean divider. Depends on bap_pkg and bap_ram.
`default_nettype none
// Pixels arrive in raster order over the region; each passes through an
// accumulator read (ST_IDLE) and a write-back into the column-sum RAM
// (ST_READ). The pixel that completes a tile then passes through ST_MULT for
// the pixel count and eight restoring-division steps that produce all three
// channel means at once, then the result is loaded into the output register
// in ST_FIN once it is free. A configuration write to a known register
// restarts the frame and blocks pixels while the region origin is reduced
// modulo the tile size, one bit per cycle.
module block_average_pixelate
   import bap_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int MAX_BLOCK = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_avg_red,
   output logic [7:0]       rsp_avg_green,
   output logic [7:0]       rsp_avg_blue,
   output logic [10:0]      rsp_tile_left,
   output logic [10:0]      rsp_tile_top,
   output logic [6:0]       rsp_tile_width,
   output logic [6:0]       rsp_tile_height,
   output logic             rsp_frame_done
);
   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int PW  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
   localparam int BW  = $clog2(MAX_BLOCK + 1);
   localparam int RW  = BW + 1;
   localparam int NW  = 2 * BW;
   localparam int SW  = PIX_W + NW;
   localparam int DW  = NW + PIX_W + 1;
   localparam int MCW = $clog2(PW + 1);

   state_type state_ff;

   logic [6:0]       block_size_ff;
   logic [CFG_W-1:0] region_left_ff, region_top_ff, region_right_ff, region_bottom_ff;
   logic             color_mode_ff;

   logic [PW-1:0] col_ff, row_ff;
   logic [BW-1:0] col_mod_ff, row_mod_ff, left_mod_ff, top_mod_ff;

   logic [PW-1:0]  mod_l_sh_ff, mod_t_sh_ff;
   logic [BW-1:0]  mod_l_rem_ff, mod_t_rem_ff;
   logic [MCW-1:0] mod_cnt_ff;

   // Transaction held while the accumulator is read and written back.
   logic [AW-1:0]    addr_ff;
   logic             first_ff, last_ff, done_ff;
   logic [PW-1:0]    cs_ff, rs_ff;
   logic [BW-1:0]    tw_ff, th_ff;
   logic [PIX_W-1:0] pr_ff, pg_ff, pb_ff;

   logic [NW-1:0] cnt_ff;
   logic [DW-1:0] rem_r_ff, rem_g_ff, rem_b_ff;
   logic [7:0]    q_r_ff, q_g_ff, q_b_ff;
   logic [2:0]    div_i_ff;

   // Effective parameters of the current configuration.
   logic [BW-1:0] bs;
   logic [PW-1:0] lc, tc, rc, bc;
   logic          empty;

   function automatic logic [PW-1:0] clamp_bound(input logic [CFG_W-1:0] v);
      logic [PW-1:0] w;
      w = PW'(v);
      return (w > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : w;
   endfunction

   always_comb begin
      if (block_size_ff == 7'd0) begin
         bs = BW'(1);
      end else if (int'(block_size_ff) > MAX_BLOCK) begin
         bs = BW'(MAX_BLOCK);
      end else begin
         bs = BW'(block_size_ff);
      end
   end

   assign lc    = clamp_bound(region_left_ff);
   assign tc    = clamp_bound(region_top_ff);
   assign rc    = clamp_bound(region_right_ff);
   assign bc    = clamp_bound(region_bottom_ff);
   assign empty = (lc >= rc) || (tc >= bc);

   // Clipped tile of the current position.
   logic [PW-1:0] c_base, r_base, cs, rs, ce_raw, re_raw, ce, re;
   logic          tile_first, tile_last, tile_done;

   assign c_base = col_ff - PW'(col_mod_ff);
   assign r_base = row_ff - PW'(row_mod_ff);
   assign cs     = (c_base < lc) ? lc : c_base;
   assign rs     = (r_base < tc) ? tc : r_base;
   assign ce_raw = c_base + PW'(bs);
   assign re_raw = r_base + PW'(bs);
   assign ce     = (ce_raw > rc) ? rc : ce_raw;
   assign re     = (re_raw > bc) ? bc : re_raw;

   assign tile_first = (col_ff == cs) && (row_ff == rs);
   assign tile_last  = (col_ff + PW'(1) == ce) && (row_ff + PW'(1) == re);
   assign tile_done  = (ce == rc) && (re == bc);

   // Next raster position.
   logic [BW-1:0] col_mod_inc, row_mod_inc;
   assign col_mod_inc = (col_mod_ff + BW'(1) == bs) ? '0 : col_mod_ff + BW'(1);
   assign row_mod_inc = (row_mod_ff + BW'(1) == bs) ? '0 : row_mod_ff + BW'(1);

   // Remainder steps for the region origin.
   logic [RW-1:0] l_rem_in, t_rem_in;
   always_comb begin
      l_rem_in = {mod_l_rem_ff, mod_l_sh_ff[PW-1]};
      if (l_rem_in >= RW'(bs)) begin
         l_rem_in = l_rem_in - RW'(bs);
      end
      t_rem_in = {mod_t_rem_ff, mod_t_sh_ff[PW-1]};
      if (t_rem_in >= RW'(bs)) begin
         t_rem_in = t_rem_in - RW'(bs);
      end
   end

   // Handshakes.
   logic req_take, csr_take, csr_known;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign req_take  = req_valid && req_ready;
   assign csr_take  = csr_valid && csr_ready;
   assign csr_known = (csr_index == REG_BLOCK_SIZE) || (csr_index == REG_REGION_LEFT)
                   || (csr_index == REG_REGION_TOP) || (csr_index == REG_REGION_RIGHT)
                   || (csr_index == REG_REGION_BOTTOM) || (csr_index == REG_COLOR_MODE);

   // Accumulator RAM: red, green and blue sums side by side.
   logic [3*SW-1:0] rd_data, wr_data;
   logic [SW-1:0]   sum_r, sum_g, sum_b;

   always_comb begin
      if (first_ff) begin
         sum_r = SW'(pr_ff);
         sum_g = SW'(pg_ff);
         sum_b = SW'(pb_ff);
      end else begin
         sum_r = rd_data[3*SW-1:2*SW] + SW'(pr_ff);
         sum_g = rd_data[2*SW-1:SW] + SW'(pg_ff);
         sum_b = rd_data[SW-1:0] + SW'(pb_ff);
      end
   end
   assign wr_data = {sum_r, sum_g, sum_b};

   bap_ram #(
      .WIDTH (3 * SW),
      .DEPTH (MAX_WIDTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_READ),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (req_take),
      .rd_addr (cs[AW-1:0]),
      .rd_data (rd_data)
   );

   // Division step: one quotient bit per channel per cycle.
   logic [DW-1:0] dv;
   logic          ge_r, ge_g, ge_b;
   assign dv   = DW'(cnt_ff) << div_i_ff;
   assign ge_r = rem_r_ff >= dv;
   assign ge_g = rem_g_ff >= dv;
   assign ge_b = rem_b_ff >= dv;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         block_size_ff    <= 7'd4;
         region_left_ff   <= '0;
         region_top_ff    <= '0;
         region_right_ff  <= '0;
         region_bottom_ff <= '0;
         color_mode_ff    <= 1'b1;
         col_ff           <= '0;
         row_ff           <= '0;
         col_mod_ff       <= '0;
         row_mod_ff       <= '0;
         left_mod_ff      <= '0;
         top_mod_ff       <= '0;
         mod_cnt_ff       <= '0;
         rsp_valid        <= 1'b0;
      end else begin
         // In the final state a taken result is replaced by the next one.
         if (rsp_valid && rsp_ready && (state_ff != ST_FIN)) begin
            rsp_valid <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (csr_take) begin
                  unique case (csr_index)
                     REG_BLOCK_SIZE:    block_size_ff    <= csr_data[6:0];
                     REG_REGION_LEFT:   region_left_ff   <= csr_data;
                     REG_REGION_TOP:    region_top_ff    <= csr_data;
                     REG_REGION_RIGHT:  region_right_ff  <= csr_data;
                     REG_REGION_BOTTOM: region_bottom_ff <= csr_data;
                     REG_COLOR_MODE:    color_mode_ff    <= csr_data[0];
                     default: ;
                  endcase
                  if (csr_known) begin
                     mod_cnt_ff <= '0;
                     state_ff   <= ST_MODS;
                  end
               end else if (req_take && !empty) begin
                  addr_ff  <= cs[AW-1:0];
                  first_ff <= tile_first;
                  last_ff  <= tile_last;
                  done_ff  <= tile_done;
                  cs_ff    <= cs;
                  rs_ff    <= rs;
                  tw_ff    <= BW'(ce - cs);
                  th_ff    <= BW'(re - rs);
                  pr_ff    <= req_red;
                  pg_ff    <= color_mode_ff ? req_green : '0;
                  pb_ff    <= color_mode_ff ? req_blue : '0;
                  state_ff <= ST_READ;
                  if (col_ff + PW'(1) >= rc) begin
                     col_ff     <= lc;
                     col_mod_ff <= left_mod_ff;
                     if (row_ff + PW'(1) >= bc) begin
                        row_ff     <= tc;
                        row_mod_ff <= top_mod_ff;
                     end else begin
                        row_ff     <= row_ff + PW'(1);
                        row_mod_ff <= row_mod_inc;
                     end
                  end else begin
                     col_ff     <= col_ff + PW'(1);
                     col_mod_ff <= col_mod_inc;
                  end
               end
            end
            ST_MODS: begin
               if (mod_cnt_ff == '0) begin
                  mod_l_sh_ff  <= lc;
                  mod_t_sh_ff  <= tc;
                  mod_l_rem_ff <= '0;
                  mod_t_rem_ff <= '0;
                  mod_cnt_ff   <= MCW'(1);
               end else begin
                  mod_l_sh_ff  <= mod_l_sh_ff << 1;
                  mod_t_sh_ff  <= mod_t_sh_ff << 1;
                  mod_l_rem_ff <= BW'(l_rem_in);
                  mod_t_rem_ff <= BW'(t_rem_in);
                  mod_cnt_ff   <= mod_cnt_ff + MCW'(1);
                  if (mod_cnt_ff == MCW'(PW)) begin
                     col_ff      <= lc;
                     row_ff      <= tc;
                     col_mod_ff  <= BW'(l_rem_in);
                     row_mod_ff  <= BW'(t_rem_in);
                     left_mod_ff <= BW'(l_rem_in);
                     top_mod_ff  <= BW'(t_rem_in);
                     state_ff    <= ST_IDLE;
                  end
               end
            end
            ST_READ: begin
               rem_r_ff <= DW'(sum_r);
               rem_g_ff <= DW'(sum_g);
               rem_b_ff <= DW'(sum_b);
               state_ff <= last_ff ? ST_MULT : ST_IDLE;
            end
            ST_MULT: begin
               cnt_ff   <= NW'(tw_ff * th_ff);
               div_i_ff <= 3'd7;
               state_ff <= ST_DIVD;
            end
            ST_DIVD: begin
               if (ge_r) begin
                  rem_r_ff <= rem_r_ff - dv;
               end
               if (ge_g) begin
                  rem_g_ff <= rem_g_ff - dv;
               end
               if (ge_b) begin
                  rem_b_ff <= rem_b_ff - dv;
               end
               q_r_ff[div_i_ff] <= ge_r;
               q_g_ff[div_i_ff] <= ge_g;
               q_b_ff[div_i_ff] <= ge_b;
               div_i_ff         <= div_i_ff - 3'd1;
               if (div_i_ff == 3'd0) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               // Wait until the output register is free.
               if (!rsp_valid || rsp_ready) begin
                  rsp_valid       <= 1'b1;
                  rsp_avg_red     <= q_r_ff;
                  rsp_avg_green   <= q_g_ff;
                  rsp_avg_blue    <= q_b_ff;
                  rsp_tile_left   <= cs_ff[10:0];
                  rsp_tile_top    <= rs_ff[10:0];
                  rsp_tile_width  <= 7'(tw_ff);
                  rsp_tile_height <= 7'(th_ff);
                  rsp_frame_done  <= done_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
